### rtl/core/operator_precedence_reducer_unit_macros.svh
// Assertion macros shared by the reducer checker.
`ifndef OPERATOR_PRECEDENCE_REDUCER_UNIT_MACROS_SVH
`define OPERATOR_PRECEDENCE_REDUCER_UNIT_MACROS_SVH

// Check prop at every rising clock edge outside reset.
`define OPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a held result keeps its payload while stalled.
`define OPR_ASSERT_HOLD(label, vld, rdy, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

### rtl/core/opr_pkg.sv
// Types, codes and precedence table of the operator precedence reducer.
`default_nettype none
package opr_pkg;

  localparam int unsigned STACK_DEPTH = 8;

  localparam int unsigned HANDLE_W = 17;
  localparam int unsigned OP_W     = 4;
  localparam int unsigned PREC_W   = 3;

  localparam logic [2:0] MAX_REDUCE = 3'd7;

  localparam logic [1:0] KIND_TERM = 2'd0;
  localparam logic [1:0] KIND_OP   = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam logic [1:0] RES_REDUCE = 2'd0;
  localparam logic [1:0] RES_ROOT   = 2'd1;
  localparam logic [1:0] RES_ERROR  = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_ORDER    = 2'd2;

  localparam logic [3:0] OP_OR    = 4'd0;
  localparam logic [3:0] OP_AND   = 4'd1;
  localparam logic [3:0] OP_PLUS  = 4'd8;
  localparam logic [3:0] OP_MINUS = 4'd9;
  localparam logic [3:0] OP_MUL   = 4'd10;
  localparam logic [3:0] OP_DIV   = 4'd11;
  localparam logic [3:0] OP_MOD   = 4'd12;

  typedef struct packed {
    logic [HANDLE_W-1:0] operand;
    logic [OP_W-1:0]     op;
    logic [PREC_W-1:0]   prec;
  } stack_entry_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] left;
    logic [HANDLE_W-1:0] right;
    logic [HANDLE_W-1:0] node;
    logic [1:0]          err;
  } result_t;

  function automatic logic [PREC_W-1:0] prec_of(input logic [OP_W-1:0] op);
    logic [PREC_W-1:0] p;
    unique case (op)
      OP_OR:                  p = 3'd0;
      OP_AND:                 p = 3'd1;
      OP_PLUS, OP_MINUS:      p = 3'd3;
      OP_MUL, OP_DIV, OP_MOD: p = 3'd4;
      default:                p = 3'd2;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

### rtl/core/opr_stack.sv
// Operand and operator stack memory, one write and one registered read port.
`default_nettype none
module opr_stack #(
  parameter int unsigned Depth = opr_pkg::STACK_DEPTH,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AddrW-1:0]     waddr_i,
  input  wire opr_pkg::stack_entry_t wdata_i,
  input  wire logic [AddrW-1:0]     raddr_i,
  output opr_pkg::stack_entry_t     rdata_o
);

  opr_pkg::stack_entry_t mem [Depth];
  opr_pkg::stack_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // forward a write to the same address
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/core/operator_precedence_reducer_unit.sv
// Top level of the operator precedence reducer.
// A term item gives no result unless it is out of order or overflows the stack, when one
// error item follows. An operator or end item is accepted, then gives one result per
// reduction, then the run is closed, and an end item also gives the root; the stack
// RAM's single registered read port sets the pace, since each reduction needs the entry
// below the top, read while the previous reduction retires. The last item of each run
// carries tlast. Results wait in an output register and the next input item is taken once
// the reducer is idle and that register is free or being drained.
`default_nettype none
module operator_precedence_reducer_unit #(
  parameter int unsigned STACK_DEPTH = opr_pkg::STACK_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // op_code[3:0], term_handle[19:4], zero pad
  input  wire logic [1:0]  s_axis_tuser,  // item_kind[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // reduce_op[3:0], left_handle[20:4],
                                          // right_handle[37:21], node_handle[54:38],
                                          // error_code[56:55], zero pad
  output logic [1:0]       m_axis_tuser,  // result_kind[1:0]
  output logic             m_axis_tlast   // last_of_run
);

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RED  = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;

  logic [1:0]                    state_q, state_d;
  logic [CntW-1:0]               count_q, count_d;
  logic [15:0]                   node_cnt_q, node_cnt_d;
  logic                          expect_q, expect_d;
  logic [opr_pkg::HANDLE_W-1:0]  top_q, top_d;
  logic [opr_pkg::OP_W-1:0]      pend_op_q, pend_op_d;
  logic [opr_pkg::PREC_W-1:0]    pend_prec_q, pend_prec_d;
  logic [opr_pkg::OP_W-1:0]      in_op_q, in_op_d;
  logic [opr_pkg::PREC_W-1:0]    min_prec_q, min_prec_d;
  logic                          is_end_q, is_end_d;
  logic [2:0]                    red_cnt_q, red_cnt_d;
  logic                          pend_valid_q, pend_valid_d;
  opr_pkg::result_t              pend_res_q, pend_res_d;
  logic                          out_valid_q, out_valid_d;
  opr_pkg::result_t              out_res_q, out_res_d;
  logic                          out_last_q, out_last_d;

  logic                          slot_free;
  logic                          in_acc;
  logic                          can_reduce;
  logic [1:0]                    in_kind;
  logic [opr_pkg::OP_W-1:0]      in_op;
  logic [15:0]                   in_handle;
  logic [opr_pkg::HANDLE_W-1:0]  node_handle;
  logic [CntW-1:0]               rd_cnt;
  logic                          we;
  logic [AddrW-1:0]              waddr;
  logic [AddrW-1:0]              raddr;
  opr_pkg::stack_entry_t         wdata;
  opr_pkg::stack_entry_t         rdata;

  assign in_kind     = s_axis_tuser;
  assign in_op       = s_axis_tdata[3:0];
  assign in_handle   = s_axis_tdata[19:4];
  assign node_handle = {1'b1, node_cnt_q};

  assign slot_free     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && slot_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign can_reduce = (count_q > CntW'(1)) && (red_cnt_q != opr_pkg::MAX_REDUCE) &&
                      (is_end_q || (rdata.prec >= min_prec_q));

  assign wdata = '{operand: top_q, op: pend_op_q, prec: pend_prec_q};
  assign waddr = AddrW'(count_q - CntW'(1));
  assign rd_cnt = count_d - CntW'(2);
  assign raddr = ((state_d == ST_ROOT) || (count_d < CntW'(2))) ? '0 : rd_cnt[AddrW-1:0];

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    node_cnt_d   = node_cnt_q;
    expect_d     = expect_q;
    top_d        = top_q;
    pend_op_d    = pend_op_q;
    pend_prec_d  = pend_prec_q;
    in_op_d      = in_op_q;
    min_prec_d   = min_prec_q;
    is_end_d     = is_end_q;
    red_cnt_d    = red_cnt_q;
    pend_valid_d = pend_valid_q;
    pend_res_d   = pend_res_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_res_d    = out_res_q;
    out_last_d   = out_last_q;
    we           = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          out_res_d  = '{kind: opr_pkg::RES_ERROR, op: '0, left: '0, right: '0,
                         node: '0, err: opr_pkg::ERR_ORDER};
          out_last_d = 1'b1;
          unique case (in_kind)
            opr_pkg::KIND_TERM: begin
              if (!expect_q) begin
                out_valid_d = 1'b1;
              end else if (count_q == CntW'(STACK_DEPTH)) begin
                out_valid_d   = 1'b1;
                out_res_d.err = opr_pkg::ERR_OVERFLOW;
              end else begin
                we       = (count_q != '0);
                top_d    = {1'b0, in_handle};
                count_d  = count_q + CntW'(1);
                expect_d = 1'b0;
              end
            end
            opr_pkg::KIND_OP: begin
              if (expect_q || (count_q == '0)) begin
                out_valid_d = 1'b1;
              end else begin
                state_d      = ST_RED;
                in_op_d      = in_op;
                min_prec_d   = opr_pkg::prec_of(in_op);
                is_end_d     = 1'b0;
                red_cnt_d    = '0;
                pend_valid_d = 1'b0;
              end
            end
            opr_pkg::KIND_END: begin
              if (expect_q || (count_q == '0)) begin
                out_valid_d = 1'b1;
                count_d     = '0;
                expect_d    = 1'b1;
              end else begin
                state_d      = ST_RED;
                is_end_d     = 1'b1;
                red_cnt_d    = '0;
                pend_valid_d = 1'b0;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_RED: begin
        if (slot_free) begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_res_d   = pend_res_q;
            out_last_d  = !can_reduce && !is_end_q;
          end
          if (can_reduce) begin
            pend_res_d   = '{kind: opr_pkg::RES_REDUCE, op: rdata.op, left: rdata.operand,
                             right: top_q, node: node_handle, err: opr_pkg::ERR_NONE};
            pend_valid_d = 1'b1;
            top_d        = node_handle;
            count_d      = count_q - CntW'(1);
            node_cnt_d   = node_cnt_q + 16'd1;
            red_cnt_d    = red_cnt_q + 3'd1;
          end else begin
            pend_valid_d = 1'b0;
            if (is_end_q) begin
              state_d = ST_ROOT;
            end else begin
              pend_op_d   = in_op_q;
              pend_prec_d = min_prec_q;
              expect_d    = 1'b1;
              state_d     = ST_IDLE;
            end
          end
        end
      end
      ST_ROOT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_res_d   = '{kind: opr_pkg::RES_ROOT, op: '0, left: '0, right: '0,
                          node: (count_q == CntW'(1)) ? top_q : rdata.operand,
                          err: opr_pkg::ERR_NONE};
          out_last_d  = 1'b1;
          count_d     = '0;
          expect_d    = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      node_cnt_q   <= '0;
      expect_q     <= 1'b1;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      red_cnt_q    <= '0;
      is_end_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      node_cnt_q   <= node_cnt_d;
      expect_q     <= expect_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      red_cnt_q    <= red_cnt_d;
      is_end_q     <= is_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q       <= top_d;
    pend_op_q   <= pend_op_d;
    pend_prec_q <= pend_prec_d;
    in_op_q     <= in_op_d;
    min_prec_q  <= min_prec_d;
    pend_res_q  <= pend_res_d;
    out_res_q   <= out_res_d;
    out_last_q  <= out_last_d;
  end

  opr_stack #(
    .Depth(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.kind;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {7'd0, out_res_q.err, out_res_q.node, out_res_q.right,
                          out_res_q.left, out_res_q.op};

endmodule
`default_nettype wire

### rtl/core/opr_checker.sv
// Port checker for the operator precedence reducer, bound to the top level.
`default_nettype none
`include "operator_precedence_reducer_unit_macros.svh"
module opr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  logic [64:0] m_word;
  logic        is_err;
  logic        is_root;
  logic        is_red;
  logic        err_ok;
  logic        root_ok;
  logic        red_ok;
  logic        out_blocked;

  assign m_word      = {m_axis_tlast, m_axis_tdata};
  assign is_err      = m_axis_tvalid && (m_axis_tuser == opr_pkg::RES_ERROR);
  assign is_root     = m_axis_tvalid && (m_axis_tuser == opr_pkg::RES_ROOT);
  assign is_red      = m_axis_tvalid && (m_axis_tuser == opr_pkg::RES_REDUCE);
  assign err_ok      = m_axis_tlast && (m_axis_tdata[54:0] == 55'd0);
  assign root_ok     = m_axis_tlast && (m_axis_tdata[37:0] == 38'd0) &&
                       (m_axis_tdata[56:55] == opr_pkg::ERR_NONE);
  assign red_ok      = m_axis_tdata[54] && (m_axis_tdata[56:55] == opr_pkg::ERR_NONE);
  assign out_blocked = m_axis_tvalid && !m_axis_tready;

  `OPR_ASSERT_HOLD(a_out_hold, m_axis_tvalid, m_axis_tready, m_word, "result changed in stall")

  `OPR_ASSERT(a_err_last, is_err |-> err_ok, "error item malformed")

  `OPR_ASSERT(a_root_last, is_root |-> root_ok, "root item malformed")

  `OPR_ASSERT(a_red_node, is_red |-> red_ok, "reduction without internal node")

  `OPR_ASSERT(a_no_take_busy, out_blocked |-> !s_axis_tready, "item taken with output blocked")

endmodule

bind operator_precedence_reducer_unit opr_checker u_opr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the operator precedence reducer unit.
`timescale 1ns / 1ps
module testbench;

  localparam logic [1:0] KIND_RSVD  = 2'd3;
  localparam logic [3:0] OP_EQ      = 4'd2;
  localparam logic [3:0] OP_EXT_LO  = 4'd13;
  localparam logic [3:0] OP_EXT_HI  = 4'd15;
  localparam int unsigned MAX_RUN   = 8;
  localparam int unsigned PHASE_LEN = 30;
  localparam int unsigned CYCLE_CAP = 200000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  op;
    logic [16:0] left;
    logic [16:0] right;
    logic [16:0] node;
    logic [1:0]  err;
    logic        last;
  } reduction_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  op;
    logic [15:0] handle;
    logic        typed;
    reduction_t  want;
  } token_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  operator_precedence_reducer_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Predictor state.
  logic [16:0] opnd_stk [opr_pkg::STACK_DEPTH];
  logic [3:0]  oper_stk [opr_pkg::STACK_DEPTH];
  logic [2:0]  level_stk [opr_pkg::STACK_DEPTH];
  int unsigned depth_cnt = 0;
  logic [15:0] node_ctr = '0;
  bit          want_term = 1'b1;

  reduction_t  staged_results [$];
  reduction_t  expected_results [$];
  int unsigned sent = 0;
  int unsigned failures = 0;
  int unsigned cycles = 0;
  int unsigned src_gap = 0;
  int unsigned dst_gap = 0;
  token_row_t  script [29];

  function automatic logic [2:0] bind_level(input logic [3:0] op);
    if (op == opr_pkg::OP_OR) return 3'd0;
    if (op == opr_pkg::OP_AND) return 3'd1;
    if (op == opr_pkg::OP_PLUS || op == opr_pkg::OP_MINUS) return 3'd3;
    if (op == opr_pkg::OP_MUL || op == opr_pkg::OP_DIV || op == opr_pkg::OP_MOD)
      return 3'd4;
    return 3'd2;
  endfunction

  function automatic reduction_t error_item(input logic [1:0] err);
    return '{opr_pkg::RES_ERROR, 4'd0, 17'd0, 17'd0, 17'd0, err, 1'b1};
  endfunction

  function automatic reduction_t root_item(input logic [16:0] handle);
    return '{opr_pkg::RES_ROOT, 4'd0, 17'd0, 17'd0, handle, opr_pkg::ERR_NONE, 1'b1};
  endfunction

  function automatic token_row_t plain(input logic [1:0] kind, input logic [3:0] op,
                                       input logic [15:0] handle);
    return '{kind, op, handle, 1'b0, reduction_t'(0)};
  endfunction

  function automatic token_row_t fixed(input logic [1:0] kind, input logic [3:0] op,
                                       input logic [15:0] handle, input reduction_t want);
    return '{kind, op, handle, 1'b1, want};
  endfunction

  function automatic logic [15:0] pick_handle();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic fold_stack(input bit all_ops, input logic [2:0] min_level);
    logic [16:0] node;
    int unsigned t;
    while (depth_cnt > 1 && staged_results.size() < MAX_RUN - 1) begin
      t = depth_cnt - 2;
      if (!all_ops && level_stk[t] < min_level) break;
      node = {1'b1, node_ctr};
      node_ctr = node_ctr + 16'd1;
      staged_results.push_back('{opr_pkg::RES_REDUCE, oper_stk[t], opnd_stk[t],
                                 opnd_stk[t+1], node, opr_pkg::ERR_NONE, 1'b0});
      opnd_stk[t] = node;
      depth_cnt--;
    end
  endtask

  task automatic parse_token(input logic [1:0] kind, input logic [3:0] op,
                             input logic [15:0] handle);
    logic [2:0] lvl;
    staged_results.delete();
    lvl = bind_level(op);
    case (kind)
      opr_pkg::KIND_TERM: begin
        if (!want_term) begin
          staged_results.push_back(error_item(opr_pkg::ERR_ORDER));
        end else if (depth_cnt >= opr_pkg::STACK_DEPTH) begin
          staged_results.push_back(error_item(opr_pkg::ERR_OVERFLOW));
        end else begin
          opnd_stk[depth_cnt] = {1'b0, handle};
          depth_cnt++;
          want_term = 1'b0;
        end
      end
      opr_pkg::KIND_OP: begin
        if (want_term || depth_cnt == 0) begin
          staged_results.push_back(error_item(opr_pkg::ERR_ORDER));
        end else begin
          fold_stack(1'b0, lvl);
          oper_stk[depth_cnt-1] = op;
          level_stk[depth_cnt-1] = lvl;
          want_term = 1'b1;
        end
      end
      opr_pkg::KIND_END: begin
        if (want_term || depth_cnt == 0) begin
          staged_results.push_back(error_item(opr_pkg::ERR_ORDER));
        end else begin
          fold_stack(1'b1, 3'd0);
          staged_results.push_back(root_item(opnd_stk[0]));
        end
        depth_cnt = 0;
        want_term = 1'b1;
      end
      default: begin
        staged_results.push_back(error_item(opr_pkg::ERR_ORDER));
      end
    endcase
    if (staged_results.size() != 0) staged_results[staged_results.size()-1].last = 1'b1;
  endtask

  // Call right after a falling edge; return right after a falling edge.
  task automatic send_token(input logic [1:0] kind, input logic [3:0] op,
                            input logic [15:0] handle, input logic typed,
                            input reduction_t want);
    while ($urandom_range(0, 99) < src_gap) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, handle, op};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_token(kind, op, handle);
    if (typed) begin
      expected_results.push_back(want);
    end else begin
      foreach (staged_results[i]) expected_results.push_back(staged_results[i]);
    end
    sent++;
    @(negedge clk_i);
  endtask

  task automatic random_expression(input bit broken);
    int unsigned terms;
    int unsigned flaw;
    int unsigned pos;
    int unsigned i;
    terms = $urandom_range(1, 8);
    flaw  = $urandom_range(0, 2);
    pos   = $urandom_range(0, terms - 1);
    for (i = 0; i < terms; i++) begin
      if (broken && flaw == 0 && i == pos)
        send_token(opr_pkg::KIND_OP, 4'($urandom_range(0, 15)), pick_handle(), 1'b0, '0);
      send_token(opr_pkg::KIND_TERM, 4'($urandom_range(0, 15)), pick_handle(), 1'b0, '0);
      if (broken && flaw == 1 && i == pos)
        send_token(opr_pkg::KIND_TERM, 4'd0, pick_handle(), 1'b0, '0);
      if (i < terms - 1)
        send_token(opr_pkg::KIND_OP, 4'($urandom_range(0, 15)), pick_handle(), 1'b0, '0);
    end
    if (broken && flaw == 2)
      send_token(opr_pkg::KIND_OP, 4'($urandom_range(0, 15)), pick_handle(), 1'b0, '0);
    send_token(opr_pkg::KIND_END, 4'($urandom_range(0, 15)), pick_handle(), 1'b0, '0);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (expected_results.size() != 0);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= dst_gap);
  end

  always @(posedge clk_i) begin
    reduction_t got;
    reduction_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[20:4], m_axis_tdata[37:21],
              m_axis_tdata[54:38], m_axis_tdata[56:55], m_axis_tlast};
      if (expected_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected item kind=%0d op=%0d left=%h right=%h node=%h err=%0d last=%0d",
                 $time, got.kind, got.op, got.left, got.right, got.node, got.err, got.last);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          failures++;
          $display("%0t: expected kind=%0d op=%0d left=%h right=%h node=%h err=%0d last=%0d",
                   $time, want.kind, want.op, want.left, want.right, want.node, want.err,
                   want.last);
          $display("%0t:   actual kind=%0d op=%0d left=%h right=%h node=%h err=%0d last=%0d",
                   $time, got.kind, got.op, got.left, got.right, got.node, got.err, got.last);
        end
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned target;
    int unsigned roll;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;

    script = '{
      fixed(opr_pkg::KIND_OP,   opr_pkg::OP_PLUS, 16'h0000, error_item(opr_pkg::ERR_ORDER)),
      fixed(opr_pkg::KIND_END,  opr_pkg::OP_OR,   16'h0000, error_item(opr_pkg::ERR_ORDER)),
      fixed(KIND_RSVD,          OP_EXT_HI,        16'hFFFF, error_item(opr_pkg::ERR_ORDER)),
      plain(opr_pkg::KIND_TERM, opr_pkg::OP_OR,   16'h0000),
      fixed(opr_pkg::KIND_TERM, OP_EXT_HI,        16'hFFFF, error_item(opr_pkg::ERR_ORDER)),
      fixed(opr_pkg::KIND_END,  opr_pkg::OP_OR,   16'h0000, root_item(17'h00000)),
      plain(opr_pkg::KIND_TERM, opr_pkg::OP_OR,    16'hFFFF),
      plain(opr_pkg::KIND_OP,   opr_pkg::OP_OR,    16'h0000),
      plain(opr_pkg::KIND_TERM, opr_pkg::OP_OR,    16'h5A5A),
      plain(opr_pkg::KIND_OP,   opr_pkg::OP_AND,   16'h0000),
      plain(opr_pkg::KIND_TERM, opr_pkg::OP_OR,    16'hA5A5),
      plain(opr_pkg::KIND_OP,   OP_EQ,             16'h0000),
      plain(opr_pkg::KIND_TERM, opr_pkg::OP_OR,    16'h0001),
      plain(opr_pkg::KIND_OP,   opr_pkg::OP_PLUS,  16'h0000),
      plain(opr_pkg::KIND_TERM, opr_pkg::OP_OR,    16'h8000),
      plain(opr_pkg::KIND_OP,   opr_pkg::OP_MUL,   16'h0000),
      plain(opr_pkg::KIND_TERM, opr_pkg::OP_OR,    16'h00FF),
      plain(opr_pkg::KIND_OP,   opr_pkg::OP_MINUS, 16'h0000),
      plain(opr_pkg::KIND_TERM, opr_pkg::OP_OR,    16'hFF00),
      plain(opr_pkg::KIND_OP,   opr_pkg::OP_DIV,   16'h0000),
      plain(opr_pkg::KIND_TERM, opr_pkg::OP_OR,    16'h1234),
      plain(opr_pkg::KIND_OP,   opr_pkg::OP_MOD,   16'h0000),
      plain(opr_pkg::KIND_TERM, opr_pkg::OP_OR,    16'hFFFF),
      plain(opr_pkg::KIND_OP,   OP_EXT_HI,         16'h0000),
      plain(opr_pkg::KIND_TERM, opr_pkg::OP_OR,    16'h0000),
      plain(opr_pkg::KIND_END,  opr_pkg::OP_OR,    16'h0000),
      plain(opr_pkg::KIND_TERM, opr_pkg::OP_OR,    16'h4321),
      plain(opr_pkg::KIND_OP,   OP_EXT_LO,         16'h0000),
      fixed(opr_pkg::KIND_END,  opr_pkg::OP_OR,   16'h0000, error_item(opr_pkg::ERR_ORDER))
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script[i])
      send_token(script[i].kind, script[i].op, script[i].handle, script[i].typed,
                 script[i].want);
    drain_results();

    for (phase = 0; phase < 3; phase++) begin
      src_gap = (phase == 0) ? 9 : (phase == 1) ? 68 : 0;
      dst_gap = (phase == 0) ? 68 : (phase == 1) ? 9 : 0;
      target = sent + PHASE_LEN;
      while (sent < target) begin
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
          random_expression(1'b0);
        end else if (roll < 90) begin
          random_expression(1'b1);
        end else begin
          send_token(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), pick_handle(),
                     1'b0, '0);
        end
      end
      drain_results();
    end

    repeat (16) @(posedge clk_i);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### operator_precedence_reducer_unit.f
+incdir+rtl/core
rtl/core/opr_pkg.sv
rtl/core/opr_stack.sv
rtl/core/operator_precedence_reducer_unit.sv
rtl/core/opr_checker.sv
sim/testbench.sv
